// ===== rtl/memory_map_bank_controller_unit_assert.svh =====
// Assertion macros shared by the bus controller.
`ifndef MEMORY_MAP_BANK_CONTROLLER_UNIT_ASSERT_SVH
`define MEMORY_MAP_BANK_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmbc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MMBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmbc: next-cycle check failed");

`endif

// ===== rtl/mmbc_pkg.sv =====
package mmbc_pkg;

   localparam int BOOT_BYTES     = 256;
   localparam int ROM_BANK_BYTES = 16384;
   localparam int STORE_DEPTH    = BOOT_BYTES + 65536;
   localparam int STORE_AW       = $clog2(STORE_DEPTH);

   localparam logic [7:0]  KIND_MBC1     = 8'h01;
   localparam logic [15:0] BOOT_EXIT_PC  = 16'h0100;
   localparam logic [15:0] IRQ_EN_ADDR   = 16'hFFFF;
   localparam logic [15:0] ECHO_LO       = 16'hC000;
   localparam logic [15:0] ECHO_HI       = 16'hFE00;
   localparam logic [15:0] WRAM_MASK     = 16'h1FFF;
   localparam logic [4:0]  BANK_LOW_MASK = 5'h1F;
   localparam logic [3:0]  RAM_EN_KEY    = 4'hA;

   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_PRELOAD = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   // Controller registers that change per transaction.
   typedef struct packed {
      logic       in_boot;
      logic [6:0] prg_bank;
      logic [1:0] sram_bank;
      logic       ram_en;
      logic       mode;
      logic [7:0] irq_en;
   } ctrl_type;

   // What the decoder asks of the store and the result stage.
   typedef struct packed {
      ctrl_type              ctrl_next;
      logic                  mem_we;
      logic [STORE_AW-1:0]   mem_waddr;
      logic                  mem_re;
      logic [STORE_AW-1:0]   mem_raddr;
      logic                  use_mem;
      logic [7:0]            alt_byte;
   } decode_type;

endpackage

// ===== rtl/memory_map_bank_controller_unit.sv =====
// Channel | Direction | Contents
// req     | in        | one bus read, bus write or store preload
// rsp     | out       | read byte and controller status, one per request
// csr     | in        | cartridge kind register, write only
//
// A request is decoded and its store access issued in the cycle it is accepted; the
// registered read data is merged into the output register when the staged request
// advances, and one request per cycle is sustained while rsp_tready stays high. A held
// output register stalls the decode stage, which then refuses requests. After reset the
// 65792-entry store is cleared one byte per cycle, and requests are refused until the
// clear is done; csr writes are taken throughout.
module memory_map_bank_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], bus_address[17:2], write_byte[25:18], cpu_pc[41:26],
   // store_index[58:42], zero fill [63:59]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte[7:0], boot_overlay_on[8], current ROM bank[15:9], current RAM bank[17:16],
   // ext_ram_enabled[18], banking_mode_now[19], zero fill [23:20]
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]           kind_ff;
   mmbc_pkg::ctrl_type   ctrl_ff;
   mmbc_pkg::decode_type dec;

   logic                 clear_ff;
   logic [mmbc_pkg::STORE_AW-1:0] clear_cnt_ff;

   logic                 stage_ff;
   logic                 stage_use_mem_ff;
   logic [7:0]           stage_alt_ff;
   logic [11:0]          stage_stat_ff;

   logic                 out_valid_ff;
   logic [19:0]          out_data_ff;

   logic                 accept;
   logic                 advance;
   logic                 mem_we_in;
   logic [mmbc_pkg::STORE_AW-1:0] mem_waddr_in;
   logic [7:0]           mem_wdata_in;
   logic [7:0]           mem_q;
   logic [7:0]           read_in;

   mmbc_decode u_decode (
      .func           (req_tdata[1:0]),
      .bus_address    (req_tdata[17:2]),
      .write_byte     (req_tdata[25:18]),
      .cpu_pc         (req_tdata[41:26]),
      .store_index    (req_tdata[58:42]),
      .cartridge_kind (kind_ff),
      .ctrl           (ctrl_ff),
      .dec            (dec)
   );

   assign advance    = stage_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!stage_ff || advance);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (clear_ff) begin
         mem_we_in    = 1'b1;
         mem_waddr_in = clear_cnt_ff;
         mem_wdata_in = 8'd0;
      end else begin
         mem_we_in    = accept && dec.mem_we;
         mem_waddr_in = dec.mem_waddr;
         mem_wdata_in = req_tdata[25:18];
      end
   end

   mmbc_ram #(
      .DEPTH (mmbc_pkg::STORE_DEPTH),
      .AW    (mmbc_pkg::STORE_AW),
      .DW    (8)
   ) u_store (
      .clock (clock),
      .we    (mem_we_in),
      .waddr (mem_waddr_in),
      .wdata (mem_wdata_in),
      .re    (accept && dec.mem_re),
      .raddr (dec.mem_raddr),
      .rdata (mem_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clear_ff) begin
         if (clear_cnt_ff == mmbc_pkg::STORE_AW'(mmbc_pkg::STORE_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end else begin
            clear_cnt_ff <= clear_cnt_ff + mmbc_pkg::STORE_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 8'd0;
      end else if (csr_wr_en) begin
         kind_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '{in_boot: 1'b1, default: '0};
      end else if (accept) begin
         ctrl_ff <= dec.ctrl_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
      end else if (accept) begin
         stage_ff <= 1'b1;
      end else if (advance) begin
         stage_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_use_mem_ff <= dec.use_mem;
         stage_alt_ff     <= dec.alt_byte;
         stage_stat_ff    <= {dec.ctrl_next.mode, dec.ctrl_next.ram_en,
                              dec.ctrl_next.sram_bank, dec.ctrl_next.prg_bank,
                              dec.ctrl_next.in_boot};
      end
   end

   assign read_in = stage_use_mem_ff ? mem_q : stage_alt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {stage_stat_ff, read_in};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_data_ff};

`include "memory_map_bank_controller_unit_assert.svh"

   `MMBC_ASSERT_SAME(a_no_accept_while_clearing, clock, reset, clear_ff, !req_tready)
   `MMBC_ASSERT_NEXT(a_stage_fills_empty_output, clock, reset,
                     stage_ff && !out_valid_ff, out_valid_ff)
   `MMBC_ASSERT_NEXT(a_boot_overlay_stays_off, clock, reset,
                     !ctrl_ff.in_boot, !ctrl_ff.in_boot)

endmodule

// ===== rtl/mmbc_ram.sv =====
module mmbc_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read data holds until the next read so a stalled result stays put.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mmbc_decode.sv =====
module mmbc_decode (
   input  logic [1:0]                         func,
   input  logic [15:0]                        bus_address,
   input  logic [7:0]                         write_byte,
   input  logic [15:0]                        cpu_pc,
   input  logic [16:0]                        store_index,
   input  logic [7:0]                         cartridge_kind,
   input  mmbc_pkg::ctrl_type                 ctrl,
   output mmbc_pkg::decode_type               dec
);

   logic                          hole;
   logic                          mbc1;
   logic                          boot_after;
   logic                          below_boot;
   logic [mmbc_pkg::STORE_AW-1:0] flat;
   logic [4:0]                    low_bank;
   logic [15:0]                   wram_off;

   always_comb begin
      hole = (bus_address >= 16'hFEA0 && bus_address < 16'hFF00) ||
             (bus_address >= 16'hFF01 && bus_address < 16'hFF04) ||
             (bus_address >= 16'hFF08 && bus_address < 16'hFF0F) ||
             (bus_address >= 16'hFF10 && bus_address < 16'hFF40);
      mbc1 = (cartridge_kind == mmbc_pkg::KIND_MBC1);

      // Work RAM and its echo share one copy in the store.
      wram_off = bus_address & mmbc_pkg::WRAM_MASK;
      if (bus_address >= mmbc_pkg::ECHO_LO && bus_address < mmbc_pkg::ECHO_HI) begin
         flat = mmbc_pkg::STORE_AW'(mmbc_pkg::BOOT_BYTES) +
                mmbc_pkg::STORE_AW'(mmbc_pkg::ECHO_LO) +
                mmbc_pkg::STORE_AW'(wram_off);
      end else begin
         flat = mmbc_pkg::STORE_AW'(mmbc_pkg::BOOT_BYTES) +
                mmbc_pkg::STORE_AW'(bus_address);
      end

      boot_after = ctrl.in_boot && (cpu_pc < mmbc_pkg::BOOT_EXIT_PC);
      below_boot = (mmbc_pkg::STORE_AW'(bus_address) <
                    mmbc_pkg::STORE_AW'(mmbc_pkg::BOOT_BYTES));
      low_bank   = write_byte[4:0] & mmbc_pkg::BANK_LOW_MASK;
      if (low_bank == 5'd0) begin
         low_bank = 5'd1;
      end

      dec.ctrl_next = ctrl;
      dec.mem_we    = 1'b0;
      dec.mem_waddr = flat;
      dec.mem_re    = 1'b0;
      dec.mem_raddr = flat;
      dec.use_mem   = 1'b0;
      dec.alt_byte  = 8'd0;

      case (mmbc_pkg::func_type'(func))
         mmbc_pkg::FUNC_READ: begin
            dec.ctrl_next.in_boot = boot_after;
            dec.mem_re = 1'b1;
            if (boot_after && below_boot) begin
               dec.mem_raddr = mmbc_pkg::STORE_AW'(bus_address);
            end
            if (hole) begin
               dec.alt_byte = 8'd0;
            end else if (bus_address == mmbc_pkg::IRQ_EN_ADDR) begin
               dec.alt_byte = ctrl.irq_en;
            end else begin
               dec.use_mem = 1'b1;
            end
         end
         mmbc_pkg::FUNC_WRITE: begin
            if (!hole) begin
               if (!bus_address[15]) begin
                  case (bus_address[14:13])
                     2'd0: begin
                        if (mbc1) begin
                           dec.ctrl_next.ram_en = (write_byte[3:0] == mmbc_pkg::RAM_EN_KEY);
                        end
                     end
                     2'd1: begin
                        if (mbc1) begin
                           dec.ctrl_next.prg_bank = {ctrl.prg_bank[6:5], low_bank};
                        end
                     end
                     2'd2: begin
                        if (mbc1) begin
                           dec.ctrl_next.sram_bank = write_byte[1:0];
                        end else begin
                           dec.ctrl_next.prg_bank = {write_byte[1:0], ctrl.prg_bank[4:0]};
                        end
                     end
                     default: begin
                        if (mbc1) begin
                           dec.ctrl_next.mode = write_byte[0];
                        end
                     end
                  endcase
               end else if (bus_address == mmbc_pkg::IRQ_EN_ADDR) begin
                  dec.ctrl_next.irq_en = write_byte;
               end else begin
                  dec.mem_we = 1'b1;
               end
            end
         end
         mmbc_pkg::FUNC_PRELOAD: begin
            dec.mem_waddr = store_index;
            dec.mem_we = (store_index < mmbc_pkg::STORE_AW'(mmbc_pkg::STORE_DEPTH));
         end
         default: begin
            dec.mem_we = 1'b0;
         end
      endcase
   end

endmodule
